FILE: src/ccbs_pkg.sv
// ----------------------------------------------------------------------------
// ccbs_pkg
// Types, widths and arithmetic helpers for closed-curve B-spline subdivision.
// ----------------------------------------------------------------------------
package ccbs_pkg;

    localparam int COORD_W = 24;
    localparam int POS_W   = 11;
    localparam int NUM_RES = 5;
    localparam int CNT_W   = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [POS_W-1:0]          pos_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        pos_t   pos;
        logic   last;
    } result_t;

    // (a + b) >>> 1, exact in 25 bits
    function automatic coord_t midpoint(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    // (a + 6*p + b) >>> 3, exact in 27 bits
    function automatic coord_t smooth(input coord_t a, input coord_t p, input coord_t b);
        logic signed [COORD_W+2:0] s;
        s = {{3{a[COORD_W-1]}}, a} + {{3{b[COORD_W-1]}}, b}
          + {{2{p[COORD_W-1]}}, p, 1'b0} + {p[COORD_W-1], p, 2'b00};
        return s[COORD_W+2:3];
    endfunction

endpackage

FILE: src/closed_curve_bspline_subdivide_unit.sv
// ----------------------------------------------------------------------------
// closed_curve_bspline_subdivide_unit
// The first result of a point is registered and on m_* in the cycle after its transaction.
// A new point is taken only as the last queued result leaves, so the single result port
// drains a steady-state point's two results first; a closing point drains up to 5.
// Reset: aresetn (sync, low) clears the point counter and the result queue.
// ----------------------------------------------------------------------------
module closed_curve_bspline_subdivide_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] point_x, [47:24] point_y
    input  logic        s_tlast,   // last_point
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [23:0] out_x, [47:24] out_y, [58:48] out_position,
                                   // [63:59] zero
    output logic        m_tlast    // out_last
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POINTS - 1);

    // ------------------------------------------------------------------
    // Polygon state: first two points, last two points, running index
    // ------------------------------------------------------------------
    ccbs_pkg::coord_t first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    ccbs_pkg::coord_t prev_x_reg, prev_y_reg, older_x_reg, older_y_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Result queue: entry 0 is presented on m_*, shift down on each output transaction
    ccbs_pkg::result_t res_reg [ccbs_pkg::NUM_RES];
    ccbs_pkg::result_t res_next [ccbs_pkg::NUM_RES];
    logic [ccbs_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic s_fire, m_fire;

    // Current point
    ccbs_pkg::coord_t cx, cy;
    logic             close_poly;
    logic             idx_zero, idx_one;

    // Operands with the single-point case folded in
    ccbs_pkg::coord_t fx, fy, px, py, sx, sy;

    ccbs_pkg::pos_t  pos_even;
    ccbs_pkg::result_t cand [ccbs_pkg::NUM_RES];
    logic [ccbs_pkg::NUM_RES-1:0] has;
    ccbs_pkg::result_t packed_res [ccbs_pkg::NUM_RES];
    logic [ccbs_pkg::CNT_W-1:0] packed_cnt;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // Take a new point once the queue is empty or its final entry leaves now
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == ccbs_pkg::CNT_W'(1)) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {5'd0, res_reg[0].pos, res_reg[0].y, res_reg[0].x};
    assign m_tlast  = res_reg[0].last;

    assign cx = s_tdata[23:0];
    assign cy = s_tdata[47:24];

    assign idx_zero   = (idx_reg == '0);
    assign idx_one    = (idx_reg == IDX_W'(1));
    // Close the polygon on the mark, or when the point budget runs out
    assign close_poly = s_tlast || (idx_reg >= IDX_LAST);

    // A lone point is its own neighbor and its own first point
    assign fx = idx_zero ? cx : first_x_reg;
    assign fy = idx_zero ? cy : first_y_reg;
    assign px = idx_zero ? cx : prev_x_reg;
    assign py = idx_zero ? cy : prev_y_reg;
    // The second point is arriving right now when the index is one
    assign sx = idx_one ? cx : second_x_reg;
    assign sy = idx_one ? cy : second_y_reg;

    assign pos_even = ccbs_pkg::pos_t'(ccbs_pkg::pos_t'(idx_reg) << 1);

    // ------------------------------------------------------------------
    // Candidate results in emission order
    // ------------------------------------------------------------------
    always_comb begin
        // smoothed previous point
        cand[0].x    = ccbs_pkg::smooth(older_x_reg, prev_x_reg, cx);
        cand[0].y    = ccbs_pkg::smooth(older_y_reg, prev_y_reg, cy);
        cand[0].pos  = ccbs_pkg::pos_t'(pos_even - ccbs_pkg::POS_W'(2));
        cand[0].last = 1'b0;
        // midpoint of the incoming edge
        cand[1].x    = ccbs_pkg::midpoint(prev_x_reg, cx);
        cand[1].y    = ccbs_pkg::midpoint(prev_y_reg, cy);
        cand[1].pos  = ccbs_pkg::pos_t'(pos_even - ccbs_pkg::POS_W'(1));
        cand[1].last = 1'b0;
        // smoothed current point, wrapping onto the first point
        cand[2].x    = ccbs_pkg::smooth(px, cx, fx);
        cand[2].y    = ccbs_pkg::smooth(py, cy, fy);
        cand[2].pos  = pos_even;
        cand[2].last = 1'b0;
        // smoothed first point
        cand[3].x    = ccbs_pkg::smooth(cx, fx, sx);
        cand[3].y    = ccbs_pkg::smooth(cy, fy, sy);
        cand[3].pos  = '0;
        cand[3].last = 1'b0;
        // closing midpoint
        cand[4].x    = ccbs_pkg::midpoint(cx, fx);
        cand[4].y    = ccbs_pkg::midpoint(cy, fy);
        cand[4].pos  = ccbs_pkg::pos_t'(pos_even + ccbs_pkg::POS_W'(1));
        cand[4].last = 1'b1;

        has[0] = !idx_zero && !idx_one;
        has[1] = !idx_zero;
        has[2] = close_poly;
        has[3] = close_poly && !idx_zero;
        has[4] = close_poly;
    end

    // Pack the present candidates to the front of the queue
    always_comb begin
        packed_cnt = '0;
        for (int k = 0; k < ccbs_pkg::NUM_RES; k++) begin
            packed_res[k] = cand[k];
        end
        for (int k = 0; k < ccbs_pkg::NUM_RES; k++) begin
            if (has[k]) begin
                packed_res[packed_cnt] = cand[k];
                packed_cnt = packed_cnt + ccbs_pkg::CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Queue control: load on an input transaction, else advance on output
    // ------------------------------------------------------------------
    always_comb begin
        cnt_next = cnt_reg;
        for (int k = 0; k < ccbs_pkg::NUM_RES; k++) begin
            res_next[k] = res_reg[k];
        end
        if (s_fire) begin
            cnt_next = packed_cnt;
            for (int k = 0; k < ccbs_pkg::NUM_RES; k++) begin
                res_next[k] = packed_res[k];
            end
        end else if (m_fire) begin
            cnt_next = cnt_reg - ccbs_pkg::CNT_W'(1);
            for (int k = 0; k < ccbs_pkg::NUM_RES - 1; k++) begin
                res_next[k] = res_reg[k+1];
            end
        end
    end

    // Restart the index after a closing point
    assign idx_next = close_poly ? '0 : idx_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_fire) begin
                idx_reg <= idx_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ccbs_pkg::NUM_RES; k++) begin
            res_reg[k] <= res_next[k];
        end
        if (s_fire) begin
            if (idx_zero) begin
                first_x_reg <= cx;
                first_y_reg <= cy;
            end
            if (idx_one) begin
                second_x_reg <= cx;
                second_y_reg <= cy;
            end
            older_x_reg <= prev_x_reg;
            older_y_reg <= prev_y_reg;
            prev_x_reg  <= cx;
            prev_y_reg  <= cy;
        end
    end

endmodule

FILE: tb/sv/ccbs_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// ccbs_scoreboard_pkg
// Expected-point predictor and in-order checker for one subdivision pass of a
// closed control polygon.
// ----------------------------------------------------------------------------
package ccbs_scoreboard_pkg;

    class subdiv_scoreboard;

        int                max_points;
        ccbs_pkg::coord_t  first_x, first_y, second_x, second_y;
        ccbs_pkg::coord_t  prev_x, prev_y, older_x, older_y;
        int                points_seen;
        ccbs_pkg::result_t refined_q[$];
        int unsigned       mismatches;

        function new(int max_pts);
            max_points  = max_pts;
            first_x     = '0;
            first_y     = '0;
            second_x    = '0;
            second_y    = '0;
            prev_x      = '0;
            prev_y      = '0;
            older_x     = '0;
            older_y     = '0;
            points_seen = 0;
            mismatches  = 0;
        endfunction

        // floor((a + b) / 2), formed in a 32-bit signed sum
        function ccbs_pkg::coord_t edge_mid(ccbs_pkg::coord_t a, ccbs_pkg::coord_t b);
            int s;
            s = int'(a) + int'(b);
            s = s >>> 1;
            return s[ccbs_pkg::COORD_W-1:0];
        endfunction

        // floor((a + 6p + b) / 8)
        function ccbs_pkg::coord_t tweak_point(ccbs_pkg::coord_t a, ccbs_pkg::coord_t p,
                                               ccbs_pkg::coord_t b);
            int s;
            s = int'(a) + 6 * int'(p) + int'(b);
            s = s >>> 3;
            return s[ccbs_pkg::COORD_W-1:0];
        endfunction

        function void push_point(ccbs_pkg::coord_t x, ccbs_pkg::coord_t y, int pos, bit last);
            ccbs_pkg::result_t r;
            r.x    = x;
            r.y    = y;
            r.pos  = pos[ccbs_pkg::POS_W-1:0];
            r.last = last;
            refined_q.push_back(r);
        endfunction

        // Note one accepted control point and queue the refined points it releases.
        function void note_point(ccbs_pkg::coord_t cx, ccbs_pkg::coord_t cy, bit mark);
            int idx;
            bit closing;
            idx     = points_seen;
            closing = mark || (idx >= max_points - 1);
            if (idx == 0) begin
                first_x = cx;
                first_y = cy;
            end else if (idx == 1) begin
                second_x = cx;
                second_y = cy;
                push_point(edge_mid(prev_x, cx), edge_mid(prev_y, cy), 1, 1'b0);
            end else begin
                push_point(tweak_point(older_x, prev_x, cx), tweak_point(older_y, prev_y, cy),
                           2 * idx - 2, 1'b0);
                push_point(edge_mid(prev_x, cx), edge_mid(prev_y, cy), 2 * idx - 1, 1'b0);
            end
            if (closing) begin
                if (idx == 0) begin
                    push_point(tweak_point(cx, cx, cx), tweak_point(cy, cy, cy), 0, 1'b0);
                    push_point(edge_mid(cx, cx), edge_mid(cy, cy), 1, 1'b1);
                end else begin
                    push_point(tweak_point(prev_x, cx, first_x),
                               tweak_point(prev_y, cy, first_y), 2 * idx, 1'b0);
                    push_point(tweak_point(cx, first_x, second_x),
                               tweak_point(cy, first_y, second_y), 0, 1'b0);
                    push_point(edge_mid(cx, first_x), edge_mid(cy, first_y),
                               2 * idx + 1, 1'b1);
                end
                points_seen = 0;
            end else begin
                points_seen = idx + 1;
            end
            older_x = prev_x;
            older_y = prev_y;
            prev_x  = cx;
            prev_y  = cy;
        endfunction

        function void check_result(ccbs_pkg::result_t got);
            ccbs_pkg::result_t want;
            if (refined_q.size() == 0) begin
                $error("unexpected result: x %0d y %0d position %0d last %0b",
                       got.x, got.y, got.pos, got.last);
                mismatches++;
                return;
            end
            want = refined_q.pop_front();
            if (got.x !== want.x) begin
                $error("out_x: expected %0d, actual %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("out_y: expected %0d, actual %0d", want.y, got.y);
                mismatches++;
            end
            if (got.pos !== want.pos) begin
                $error("out_position: expected %0d, actual %0d", want.pos, got.pos);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("out_last: expected %0b, actual %0b", want.last, got.last);
                mismatches++;
            end
        endfunction

        function int pending();
            return refined_q.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams closed control polygons into the subdivision unit and checks every
// refined point, in order, against an in-bench predictor. Covers single and
// two-point polygons, coordinate extremes, random polygon sizes, and random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               POLY_LIMIT   = 1024;
    localparam int               RESET_CYCLES = 11;
    localparam int               HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int               TAIL_CYCLES  = 16;    // settle time after the last result
    localparam int               PHASE_POINTS = 24;    // minimum random points per idling phase
    localparam int               CYCLE_LIMIT  = 200000;
    localparam ccbs_pkg::coord_t C_MAX        = 24'h7FFFFF;
    localparam ccbs_pkg::coord_t C_MIN        = 24'h800000;
    localparam ccbs_pkg::coord_t C_NEG1       = 24'hFFFFFF;
    localparam ccbs_pkg::coord_t C_ZERO       = 24'h000000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // [23:0] point_x, [47:24] point_y
    logic        s_tlast  = 1'b0;  // last_point
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [23:0] out_x, [47:24] out_y, [58:48] out_position
    logic        m_tlast;          // out_last

    ccbs_scoreboard_pkg::subdiv_scoreboard sb = new(POLY_LIMIT);

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    closed_curve_bspline_subdivide_unit #(
        .MAX_POINTS(POLY_LIMIT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely for a counted stretch
    // when the stimulus asks for it, so the unit backs up into s_tready.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor: unpack each accepted result transaction and check it.
    always @(posedge aclk) begin
        ccbs_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[23:0];
            got.y    = m_tdata[47:24];
            got.pos  = m_tdata[58:48];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    // Offer one point; called and returning at a falling edge. Valid stays
    // high across back-to-back points, so it is only lowered inside a gap.
    task automatic send_point(ccbs_pkg::coord_t x, ccbs_pkg::coord_t y, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {y, x};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_point(x, y, last);
        @(negedge aclk);
    endtask

    // Pause the sender until every expected point has come back, then settle.
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // Bias toward the coordinate extremes, otherwise a full random word.
    function automatic ccbs_pkg::coord_t pick_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return C_ZERO;
            3:       return C_NEG1;
            default: return r[ccbs_pkg::COORD_W-1:0];
        endcase
    endfunction

    // Mostly small polygons, some of medium size, a few large.
    function automatic int pick_poly_size();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return $urandom_range(1, 6);
        if (sel < 9) return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    task automatic send_random_polygon(int n);
        for (int i = 0; i < n; i++) begin
            send_point(pick_coord(), pick_coord(), i == n - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        bit failed;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: single-point polygons at both extremes, the result equals p0.
        send_point(C_MAX, C_MIN, 1'b1);
        send_point(C_MIN, C_MAX, 1'b1);
        send_point(C_NEG1, C_ZERO, 1'b1);
        // Two-point polygons: neighbors wrap onto the other point.
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b1);
        send_point(C_NEG1, C_NEG1, 1'b0);
        send_point(24'h000001, 24'h000001, 1'b1);
        // Three and five points: smoothed and midpoint rounding toward minus infinity.
        send_point(C_ZERO, C_NEG1, 1'b0);
        send_point(C_NEG1, C_MAX, 1'b0);
        send_point(C_MAX, C_ZERO, 1'b1);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(24'h000003, 24'hFFFFFD, 1'b0);
        send_point(24'h555555, 24'hAAAAAA, 1'b0);
        send_point(24'hAAAAAA, 24'h555555, 1'b1);
        await_results();

        // Random polygons under each idling profile.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req       = 1'b1;   // fill the unit while the sink holds off
                end
                1: begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            sent = 0;
            while (sent < PHASE_POINTS) begin
                n = pick_poly_size();
                send_random_polygon(n);
                sent += n;
            end
            await_results();
        end

        failed = (sb.mismatches != 0) || (sb.pending() != 0);
        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
